FILE: rtl/dct2d_pkg.sv
// Shared types, sizes and cosine tables for the 2-D forward DCT block.
// Used by every module of the block but the RAM; depends on nothing else.

package dct2d_pkg;

	localparam int ROWS = 8;
	localparam int COLS = 8;

	// Clamped block sizes.
	localparam int RSZ = (ROWS < 1) ? 1 : ((ROWS > 8) ? 8 : ROWS);
	localparam int CSZ = (COLS < 1) ? 1 : ((COLS > 8) ? 8 : COLS);
	localparam int BLK = RSZ * CSZ;

	// The sample store always spans the largest block.
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = 6;
	localparam int IDX_W       = 3;
	localparam int SAMPLE_W    = 16;
	localparam int COEF_W      = 32;
	localparam int COS_W       = 16;
	localparam int PROD1_W     = SAMPLE_W + COS_W;
	localparam int PROD2_W     = PROD1_W + COS_W;
	localparam int ACC_W       = PROD2_W + 5;
	localparam int ROUND_SHIFT = 22;

	localparam logic [ADDR_W-1:0] BLK_LAST = ADDR_W'(BLK - 1);
	localparam logic [IDX_W-1:0]  ROW_LAST = IDX_W'(RSZ - 1);
	localparam logic [IDX_W-1:0]  COL_LAST = IDX_W'(CSZ - 1);

	typedef logic [63:0][COS_W-1:0] cos_tab_t;

	// round(32768 * cos(pi*k/(2n))) for n in 1..8, k in 0..n, with 1.0 held at 32767.
	localparam logic [0:8][0:8][COS_W-1:0] QUARTER_COS = '{
		'{16'd0,     16'd0,     16'd0,     16'd0,     16'd0,
		  16'd0,     16'd0,     16'd0,     16'd0},
		'{16'd32767, 16'd0,     16'd0,     16'd0,     16'd0,
		  16'd0,     16'd0,     16'd0,     16'd0},
		'{16'd32767, 16'd23170, 16'd0,     16'd0,     16'd0,
		  16'd0,     16'd0,     16'd0,     16'd0},
		'{16'd32767, 16'd28378, 16'd16384, 16'd0,     16'd0,
		  16'd0,     16'd0,     16'd0,     16'd0},
		'{16'd32767, 16'd30274, 16'd23170, 16'd12540, 16'd0,
		  16'd0,     16'd0,     16'd0,     16'd0},
		'{16'd32767, 16'd31164, 16'd26510, 16'd19261, 16'd10126,
		  16'd0,     16'd0,     16'd0,     16'd0},
		'{16'd32767, 16'd31651, 16'd28378, 16'd23170, 16'd16384,
		  16'd8481,  16'd0,     16'd0,     16'd0},
		'{16'd32767, 16'd31946, 16'd29523, 16'd25619, 16'd20431,
		  16'd14218, 16'd7292,  16'd0,     16'd0},
		'{16'd32767, 16'd32138, 16'd30274, 16'd27246, 16'd23170,
		  16'd18205, 16'd12540, 16'd6393,  16'd0}
	};

	// Entry {x,k} holds cos(pi/n * (x + 1/2) * k) in Q1.15, folded onto the quarter wave.
	function automatic cos_tab_t cos_tab(input int n);
		cos_tab_t tab;
		int x;
		int k;
		int p;
		tab = '0;
		for (int e = 0; e < 64; e++) begin
			x = e >> 3;
			k = e & 7;
			if (x < n && k < n) begin
				p = (2 * x + 1) * k;
				for (int r = 0; r < 8; r++) begin
					if (p >= 4 * n)
						p = p - 4 * n;
				end
				if (p > 2 * n)
					p = 4 * n - p;
				if (p > n)
					tab[e] = COS_W'(16'd0 - QUARTER_COS[n][2 * n - p]);
				else
					tab[e] = QUARTER_COS[n][p];
			end
		end
		return tab;
	endfunction

	localparam cos_tab_t COS_ROW = cos_tab(RSZ);
	localparam cos_tab_t COS_COL = cos_tab(CSZ);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_WAIT,
		ST_ISSUE,
		ST_DRAIN
	} seq_state_t;

	// One term handed from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic                    valid;
		logic                    first_term;
		logic                    last_term;
		logic signed [COS_W-1:0] cos_row;
		logic signed [COS_W-1:0] cos_col;
	} mac_term_t;

endpackage

FILE: rtl/dct2d_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the sample store of the DCT block.

module dct2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

FILE: rtl/dct2d_mac.sv
// Shared multiply-accumulate unit: two registered multiplies, an exact accumulator,
// and Q23.8 rounding of the finished sum. Depends on dct2d_pkg.

module dct2d_mac (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  dct2d_pkg::mac_term_t                   term_s1,
	input  logic signed [dct2d_pkg::SAMPLE_W-1:0]  sample_s1,
	output logic                                   res_valid,
	output logic [dct2d_pkg::COEF_W-1:0]           coefficient
);

	logic                                   valid_s2, first_s2, last_s2;
	logic                                   valid_s3, first_s3, last_s3;
	logic signed [dct2d_pkg::PROD1_W-1:0]   prod1_s2;
	logic signed [dct2d_pkg::COS_W-1:0]     cos_col_s2;
	logic signed [dct2d_pkg::PROD2_W-1:0]   prod2_s3;
	logic signed [dct2d_pkg::ACC_W-1:0]     acc_q;
	logic signed [dct2d_pkg::ACC_W-1:0]     prod2_ext;
	logic signed [dct2d_pkg::ACC_W-1:0]     rounded;
	logic                                   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			first_s2 <= 1'b0;
			last_s2  <= 1'b0;
			valid_s3 <= 1'b0;
			first_s3 <= 1'b0;
			last_s3  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s2 <= term_s1.valid;
			first_s2 <= term_s1.first_term;
			last_s2  <= term_s1.last_term;
			valid_s3 <= valid_s2;
			first_s3 <= first_s2;
			last_s3  <= last_s2;
			done_q   <= valid_s3 && last_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod1_s2   <= sample_s1 * $signed(term_s1.cos_row);
		cos_col_s2 <= $signed(term_s1.cos_col);
		prod2_s3   <= prod1_s2 * cos_col_s2;
		if (valid_s3) begin
			if (first_s3)
				acc_q <= prod2_ext;
			else
				acc_q <= acc_q + prod2_ext;
		end
	end

	assign prod2_ext = dct2d_pkg::ACC_W'(prod2_s3);

	// The sum stays below 2^51 in magnitude, so the shifted result always fits in
	// 32 bits and the saturation limits are never reached.
	assign rounded     = acc_q + dct2d_pkg::ACC_W'(1 << (dct2d_pkg::ROUND_SHIFT - 1));
	assign coefficient = dct2d_pkg::COEF_W'(rounded >>> dct2d_pkg::ROUND_SHIFT);
	assign res_valid   = done_q;

endmodule

FILE: rtl/dct2d_seq.sv
// Sequencer of the DCT block: loads samples, waits for a free output register, then walks
// the (u,v,i,j) loops feeding one term per cycle to the shared MAC. Depends on dct2d_pkg.

module dct2d_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic                                out_free,
	input  logic                                res_valid,
	output logic                                coef_last,
	output logic                                ram_we,
	output logic [dct2d_pkg::ADDR_W-1:0]        ram_waddr,
	output logic                                ram_re,
	output logic [dct2d_pkg::ADDR_W-1:0]        ram_raddr,
	output dct2d_pkg::mac_term_t                term_s1
);

	dct2d_pkg::seq_state_t              state_q, state_d;
	logic [dct2d_pkg::ADDR_W-1:0]       load_q;
	logic [dct2d_pkg::ADDR_W-1:0]       addr_q;
	logic [dct2d_pkg::IDX_W-1:0]        i_q, j_q, u_q, v_q;
	logic                               issue;
	logic                               issue_last;

	assign issue_last = (addr_q == dct2d_pkg::BLK_LAST);
	assign coef_last  = (u_q == dct2d_pkg::ROW_LAST) && (v_q == dct2d_pkg::COL_LAST);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dct2d_pkg::ST_LOAD: begin
				if (s_tvalid && load_q == dct2d_pkg::BLK_LAST)
					state_d = dct2d_pkg::ST_WAIT;
			end
			dct2d_pkg::ST_WAIT: begin
				if (out_free)
					state_d = dct2d_pkg::ST_ISSUE;
			end
			dct2d_pkg::ST_ISSUE: begin
				if (issue_last)
					state_d = dct2d_pkg::ST_DRAIN;
			end
			dct2d_pkg::ST_DRAIN: begin
				if (res_valid)
					state_d = coef_last ? dct2d_pkg::ST_LOAD : dct2d_pkg::ST_WAIT;
			end
			default: state_d = dct2d_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		issue    = 1'b0;
		unique case (state_q)
			dct2d_pkg::ST_LOAD:  s_tready = 1'b1;
			dct2d_pkg::ST_ISSUE: issue    = 1'b1;
			default: ;
		endcase
	end

	assign ram_we    = s_tready && s_tvalid;
	assign ram_waddr = load_q;
	assign ram_re    = issue;
	assign ram_raddr = addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dct2d_pkg::ST_LOAD;
			load_q  <= '0;
			addr_q  <= '0;
			i_q     <= '0;
			j_q     <= '0;
			u_q     <= '0;
			v_q     <= '0;
			term_s1 <= '0;
		end else begin
			state_q <= state_d;

			if (ram_we)
				load_q <= (load_q == dct2d_pkg::BLK_LAST) ? '0 : load_q + 1'b1;

			// Terms go out in store order, so the read address is a plain counter.
			if (issue) begin
				addr_q <= issue_last ? '0 : addr_q + 1'b1;
				if (j_q == dct2d_pkg::COL_LAST) begin
					j_q <= '0;
					i_q <= (i_q == dct2d_pkg::ROW_LAST) ? '0 : i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end

			if (state_q == dct2d_pkg::ST_DRAIN && res_valid) begin
				if (v_q == dct2d_pkg::COL_LAST) begin
					v_q <= '0;
					u_q <= (u_q == dct2d_pkg::ROW_LAST) ? '0 : u_q + 1'b1;
				end else begin
					v_q <= v_q + 1'b1;
				end
			end

			// Aligned with the registered RAM read data.
			term_s1.valid      <= issue;
			term_s1.first_term <= (addr_q == '0);
			term_s1.last_term  <= issue_last;
			term_s1.cos_row    <= $signed(dct2d_pkg::COS_ROW[{i_q, u_q}]);
			term_s1.cos_col    <= $signed(dct2d_pkg::COS_COL[{j_q, v_q}]);
		end
	end

endmodule

FILE: rtl/dct2d_forward.sv
// Top level of the 8x8 forward 2-D DCT-II: sample store, sequencer, shared MAC
// and the output register. Depends on dct2d_pkg, dct2d_ram, dct2d_seq, dct2d_mac.
//
//   channel   dir   tdata fields (low bit up)      tlast
//   s_*       in    sample[15:0] (signed)          -
//   m_*       out   coefficient[31:0] (Q23.8)      last_coefficient
//
// Loading accepts one sample per cycle while s_tvalid is high; the block is ready only while loading.
// Each coefficient first waits for the output register to be free, then passes every
// term of the block through the shared multiply-accumulate unit and drains its pipeline.
// A coefficient starts only when the output register is free, so a stalled
// output holds the sequencer. Reset returns to loading with an empty block.

module dct2d_forward (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [dct2d_pkg::SAMPLE_W-1:0]     s_tdata,   // [15:0] sample
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [dct2d_pkg::COEF_W-1:0]       m_tdata,   // [31:0] coefficient
	output logic                               m_tlast
);

	logic                                   ram_we, ram_re;
	logic [dct2d_pkg::ADDR_W-1:0]           ram_waddr, ram_raddr;
	logic [dct2d_pkg::SAMPLE_W-1:0]         ram_rdata;
	dct2d_pkg::mac_term_t                   term_s1;
	logic                                   res_valid, coef_last, out_free;
	logic [dct2d_pkg::COEF_W-1:0]           coefficient;
	logic                                   m_tvalid_q, m_tlast_q;
	logic [dct2d_pkg::COEF_W-1:0]           m_tdata_q;

	assign out_free = !m_tvalid_q || m_tready;

	dct2d_ram #(
		.WIDTH(dct2d_pkg::SAMPLE_W),
		.DEPTH(dct2d_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (s_tdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	dct2d_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.out_free  (out_free),
		.res_valid (res_valid),
		.coef_last (coef_last),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.term_s1   (term_s1)
	);

	dct2d_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.term_s1     (term_s1),
		.sample_s1   ($signed(ram_rdata)),
		.res_valid   (res_valid),
		.coefficient (coefficient)
	);

	// A result only lands when the register was free at the start of its coefficient.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_tdata_q <= coefficient;
			m_tlast_q <= coef_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

FILE: rtl/dct2d_checker.sv
// Port-level checker for the 2-D DCT block, attached to the top level by bind.
// Depends on dct2d_pkg and the dct2d_forward port list.

module dct2d_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [dct2d_pkg::COEF_W-1:0]       m_tdata,
	input logic                               m_tlast
);

	logic [dct2d_pkg::ADDR_W-1:0] in_cnt_q, out_cnt_q;
	logic                         in_word, out_word;

	assign in_word  = s_tvalid && s_tready;
	assign out_word = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (in_word)
				in_cnt_q <= (in_cnt_q == dct2d_pkg::BLK_LAST) ? '0 : in_cnt_q + 1'b1;
			if (out_word)
				out_cnt_q <= (out_cnt_q == dct2d_pkg::BLK_LAST) ? '0 : out_cnt_q + 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_word |-> (m_tlast == (out_cnt_q == dct2d_pkg::BLK_LAST)))
		else $error("last flag not on the final coefficient of the block");

	a_busy_after_block: assert property (@(posedge clk) disable iff (!arst_n)
		in_word && in_cnt_q == dct2d_pkg::BLK_LAST |=> !s_tready)
		else $error("input taken right after the final sample of a block");

	a_no_early_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_cnt_q != '0 && out_cnt_q == '0 |-> !m_tvalid)
		else $error("coefficient shown before the block was complete");

endmodule

bind dct2d_forward dct2d_checker u_dct2d_checker (.*);

FILE: verif/tb_dct2d_forward.sv
// Self-checking testbench for dct2d_forward: streams 8x8 sample blocks in and
// checks every Q23.8 coefficient against a predictor kept inside the bench.
// Depends on dct2d_pkg and the dct2d_forward RTL.

module tb_dct2d_forward;

	localparam int QUIET_LIMIT = 20000;
	localparam int RANDOM_BLOCKS = 4;

	// round(32768 * cos(pi*k/(2n))) for n in 1..8, k in 0..n, with 1.0 held at 32767.
	localparam int QUARTER_TAB [0:8][0:8] = '{
		'{0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{32767, 0, 0, 0, 0, 0, 0, 0, 0},
		'{32767, 23170, 0, 0, 0, 0, 0, 0, 0},
		'{32767, 28378, 16384, 0, 0, 0, 0, 0, 0},
		'{32767, 30274, 23170, 12540, 0, 0, 0, 0, 0},
		'{32767, 31164, 26510, 19261, 10126, 0, 0, 0, 0},
		'{32767, 31651, 28378, 23170, 16384, 8481, 0, 0, 0},
		'{32767, 31946, 29523, 25619, 20431, 14218, 7292, 0, 0},
		'{32767, 32138, 30274, 27246, 23170, 18205, 12540, 6393, 0}
	};

	typedef enum int {
		BLK_ALL_MIN,
		BLK_ALL_MAX,
		BLK_CHECKER,
		BLK_IMPULSE,
		BLK_RANDOM,
		BLK_SMALL,
		BLK_EXTREME,
		BLK_RAMP
	} block_kind_t;

	typedef struct {
		logic [dct2d_pkg::COEF_W-1:0] coefficient;
		logic                         last;
	} coef_word_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                s_tvalid = 1'b0;
	logic                                s_tready;
	logic [dct2d_pkg::SAMPLE_W-1:0]      s_tdata = '0;
	logic                                m_tvalid;
	logic                                m_tready = 1'b0;
	logic [dct2d_pkg::COEF_W-1:0]        m_tdata;
	logic                                m_tlast;

	logic [dct2d_pkg::SAMPLE_W-1:0]      sample_queue [$];
	coef_word_t                          coef_expect [$];
	logic signed [dct2d_pkg::SAMPLE_W-1:0] block_buf [64];
	int                                  fill_count = 0;
	int                                  fail_count = 0;
	int                                  quiet_cycles = 0;
	int                                  src_gap = 0;
	int                                  sink_gap = 0;
	bit                                  src_idle = 1'b0;
	bit                                  sink_idle = 1'b0;

	dct2d_forward u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		if (fail_count < 100)
			$display("MISMATCH at %0t: %s", $time, msg);
		fail_count++;
	endtask

	// cos(pi * m / (2n)) in Q1.15, folded onto the quarter wave.
	function automatic longint cos_fold(input int n, input int m);
		int p;
		p = m % (4 * n);
		if (p > 2 * n)
			p = 4 * n - p;
		if (p > n)
			return -longint'(QUARTER_TAB[n][2 * n - p]);
		return longint'(QUARTER_TAB[n][p]);
	endfunction

	// Direct-form 2-D DCT-II of the buffered block, rounded to Q23.8 and saturated.
	function automatic void compute_coefficients();
		longint acc;
		longint res;
		coef_word_t w;
		for (int u = 0; u < dct2d_pkg::RSZ; u++) begin
			for (int v = 0; v < dct2d_pkg::CSZ; v++) begin
				acc = 0;
				for (int i = 0; i < dct2d_pkg::RSZ; i++) begin
					for (int j = 0; j < dct2d_pkg::CSZ; j++) begin
						acc += longint'(block_buf[i * dct2d_pkg::CSZ + j])
							* cos_fold(dct2d_pkg::RSZ, (2 * i + 1) * u)
							* cos_fold(dct2d_pkg::CSZ, (2 * j + 1) * v);
					end
				end
				res = (acc + (longint'(1) <<< 21)) >>> 22;
				if (res > longint'(32'sh7FFF_FFFF))
					res = longint'(32'sh7FFF_FFFF);
				if (res < -longint'(64'h8000_0000))
					res = -longint'(64'h8000_0000);
				w.coefficient = res[dct2d_pkg::COEF_W-1:0];
				w.last = (u == dct2d_pkg::RSZ - 1) && (v == dct2d_pkg::CSZ - 1);
				coef_expect.insert(coef_expect.size(), w);
			end
		end
	endfunction

	function automatic logic [dct2d_pkg::SAMPLE_W-1:0] make_sample(input block_kind_t kind,
		input int idx);
		int r;
		int c;
		r = idx / dct2d_pkg::CSZ;
		c = idx % dct2d_pkg::CSZ;
		case (kind)
			BLK_ALL_MIN: return 16'h8000;
			BLK_ALL_MAX: return 16'h7FFF;
			BLK_CHECKER: return ((r + c) % 2 == 1) ? 16'h8000 : 16'h7FFF;
			BLK_IMPULSE: return (idx == 0) ? 16'h8000 :
				((idx == dct2d_pkg::BLK - 1) ? 16'h7FFF : 16'h0000);
			BLK_SMALL:   return 16'($signed($urandom_range(0, 127)) - 64);
			BLK_EXTREME: begin
				case ($urandom_range(0, 3))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'hFFFF;
					default: return 16'h0000;
				endcase
			end
			BLK_RAMP:    return 16'(idx * 500 - 16000 + $signed($urandom_range(0, 63)));
			default:     return 16'($urandom);
		endcase
	endfunction

	task automatic send_block(input block_kind_t kind, input bit src_on, input bit sink_on);
		while (sample_queue.size() != 0)
			@(posedge clk);
		src_idle = src_on;
		sink_idle = sink_on;
		for (int k = 0; k < dct2d_pkg::BLK; k++)
			sample_queue.insert(sample_queue.size(), make_sample(kind, k));
	endtask

	// Sender: a new word goes out once the previous one is taken; with src_idle set, random gaps are inserted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (sample_queue.size() != 0) begin
				s_tdata <= sample_queue.pop_front();
				s_tvalid <= 1'b1;
				if (src_idle && $urandom_range(0, 3) == 0)
					src_gap = $urandom_range(1, 9);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (sink_idle && $urandom_range(0, 3) == 0)
				sink_gap = $urandom_range(1, 9);
		end
	end

	// Monitor: the predictor runs on accepted samples, the checker on accepted coefficients.
	always @(posedge clk) begin
		coef_word_t w;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				block_buf[fill_count] = s_tdata;
				fill_count++;
				if (fill_count == dct2d_pkg::BLK) begin
					compute_coefficients();
					fill_count = 0;
				end
			end
			if (m_tvalid && m_tready) begin
				if (coef_expect.size() == 0) begin
					report_mismatch($sformatf("unexpected coefficient %h", m_tdata));
				end else begin
					w = coef_expect.pop_front();
					if (m_tdata !== w.coefficient)
						report_mismatch($sformatf("coefficient got %h want %h",
							m_tdata, w.coefficient));
					if (m_tlast !== w.last)
						report_mismatch($sformatf("last_coefficient got %b want %b",
							m_tlast, w.last));
				end
			end
		end
	end

	// Watchdog on cycles with no word moving on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_block(BLK_ALL_MIN, 1'b1, 1'b1);
		send_block(BLK_ALL_MAX, 1'b0, 1'b0);
		send_block(BLK_CHECKER, 1'b1, 1'b0);
		send_block(BLK_IMPULSE, 1'b0, 1'b1);

		for (int b = 0; b < RANDOM_BLOCKS; b++) begin
			if (b == RANDOM_BLOCKS - 1)
				send_block(BLK_RANDOM, 1'b0, 1'b0);
			else
				send_block(block_kind_t'(BLK_RANDOM + $urandom_range(0, 3)),
					1'($urandom), 1'($urandom));
		end

		while (sample_queue.size() != 0 || s_tvalid)
			@(posedge clk);
		while (coef_expect.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (coef_expect.size() != 0)
			report_mismatch($sformatf("%0d coefficients never arrived", coef_expect.size()));

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
